### sv/rqtp_pkg.sv
package rqtp_pkg;

  localparam int unsigned QueueDepthDef = 16;
  localparam int unsigned RunCountWidthDef = 16;

  localparam logic [1:0] REQ_CREATE = 2'd0;
  localparam logic [1:0] REQ_DISPATCH = 2'd1;
  localparam logic [1:0] REQ_YIELD = 2'd2;
  localparam logic [1:0] REQ_FINISH = 2'd3;

  localparam logic [1:0] POL_RR = 2'd0;
  localparam logic [1:0] POL_PRIO = 2'd1;
  localparam logic [1:0] POL_FAIR = 2'd2;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_EMPTY = 3'd1;
  localparam logic [2:0] ST_FULL = 3'd2;
  localparam logic [2:0] ST_IDLE = 3'd3;
  localparam logic [2:0] ST_BUSY = 3'd4;

  localparam logic [0:0] REG_PICK_POLICY = 1'd0;

  // control broadcast from the sequencer to every cell
  typedef struct packed {
    logic shift;     // all cells take their right neighbor's entry
    logic load_tail; // cell at tail index takes the broadcast entry
  } rqtp_ctrl_t;

endpackage

### sv/rqtp_cell.sv
// one queue slot; during a rotation it takes its neighbor's entry
module rqtp_cell import rqtp_pkg::*; #(
  parameter int unsigned RunW = RunCountWidthDef
) (
  input  logic            clk_i,
  input  rqtp_ctrl_t      ctrl_i,
  input  logic            is_tail_i,
  input  logic [7:0]      nb_id_i,
  input  logic [7:0]      nb_prio_i,
  input  logic [RunW-1:0] nb_runs_i,
  input  logic [7:0]      ld_id_i,
  input  logic [7:0]      ld_prio_i,
  input  logic [RunW-1:0] ld_runs_i,
  output logic [7:0]      id_o,
  output logic [7:0]      prio_o,
  output logic [RunW-1:0] runs_o
);

  logic [7:0]      id_q, id_d;
  logic [7:0]      prio_q, prio_d;
  logic [RunW-1:0] runs_q, runs_d;

  always_comb begin
    id_d = id_q;
    prio_d = prio_q;
    runs_d = runs_q;
    if (ctrl_i.load_tail && is_tail_i) begin
      id_d = ld_id_i;
      prio_d = ld_prio_i;
      runs_d = ld_runs_i;
    end else if (ctrl_i.shift) begin
      id_d = nb_id_i;
      prio_d = nb_prio_i;
      runs_d = nb_runs_i;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q <= id_d;
    prio_q <= prio_d;
    runs_q <= runs_d;
  end

  assign id_o = id_q;
  assign prio_o = prio_q;
  assign runs_o = runs_q;

endmodule

### sv/ready_queue_thread_picker_unit.sv
// channel | direction | signals
// request | in        | req_valid_i, req_ready_o, req_type_i, thread_priority_i
// result  | out       | rsp_valid_o, rsp_ready_i, status_o, thread_id_o
// config  | apb       | psel, penable, pwrite, paddr, pwdata, prdata, pready
// create, yield, finish and refused requests show their result in the cycle after acceptance.
// a dispatch rotates the cell chain once in S_SCAN; S_DONE then registers its result.
// each rotation step moves every entry one cell toward the head; the head
// entry is compared with the current best and either kept or re-entered at tail.
// the request side stays blocked until the pending result is taken.
// reset empties the queue and running slot; queue cells hold no reset value.
module ready_queue_thread_picker_unit import rqtp_pkg::*; #(
  parameter int unsigned QueueDepth = QueueDepthDef,
  parameter int unsigned RunCountWidth = RunCountWidthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        req_valid_i,
  output logic        req_ready_o,
  input  logic [1:0]  req_type_i,
  input  logic signed [7:0] thread_priority_i,
  output logic        rsp_valid_o,
  input  logic        rsp_ready_i,
  output logic [2:0]  status_o,
  output logic [7:0]  thread_id_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [0:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned IdxW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);
  localparam int unsigned RW = RunCountWidth;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DONE} state_e;

  state_e          state_q;
  logic [CntW-1:0] count_q;
  logic [CntW-1:0] left_q;
  logic            run_v_q;
  logic [7:0]      run_id_q, run_prio_q;
  logic [RW-1:0]   run_runs_q;
  logic [7:0]      next_id_q;
  logic [1:0]      policy_q;
  logic            best_v_q;
  logic [7:0]      best_id_q, best_prio_q;
  logic [RW-1:0]   best_runs_q;
  logic            rsp_v_q;
  logic [2:0]      rsp_st_q;
  logic [7:0]      rsp_id_q;

  logic [7:0]    c_id [QueueDepth];
  logic [7:0]    c_prio [QueueDepth];
  logic [RW-1:0] c_runs [QueueDepth];
  rqtp_ctrl_t    ctrl;
  logic [7:0]    ld_id, ld_prio;
  logic [RW-1:0] ld_runs;
  logic [IdxW-1:0] tail_idx;

  for (genvar g = 0; g < QueueDepth; g++) begin : g_cell
    localparam int unsigned Nb = (g + 1 < QueueDepth) ? g + 1 : g;
    rqtp_cell #(.RunW(RW)) u_cell (
      .clk_i    (clk_i),
      .ctrl_i   (ctrl),
      .is_tail_i(tail_idx == IdxW'(g)),
      .nb_id_i  (c_id[Nb]),
      .nb_prio_i(c_prio[Nb]),
      .nb_runs_i(c_runs[Nb]),
      .ld_id_i  (ld_id),
      .ld_prio_i(ld_prio),
      .ld_runs_i(ld_runs),
      .id_o     (c_id[g]),
      .prio_o   (c_prio[g]),
      .runs_o   (c_runs[g])
    );
  end

  logic          req_acc;
  logic          head_wins;
  logic          pol_scan;
  logic [RW-1:0] yruns;

  assign pready = 1'b1;
  assign prdata = (paddr == REG_PICK_POLICY) ? {30'd0, policy_q} : 32'd0;
  assign req_ready_o = (state_q == S_IDLE) && !rsp_v_q;
  assign req_acc = req_valid_i && req_ready_o;
  assign pol_scan = (policy_q == POL_PRIO) || (policy_q == POL_FAIR);
  assign yruns = (run_runs_q == {RW{1'b1}}) ? run_runs_q : run_runs_q + RW'(1);

  always_comb begin
    if (!best_v_q) head_wins = 1'b1;
    else if (!pol_scan) head_wins = 1'b0;
    else if (policy_q == POL_PRIO) head_wins = $signed(c_prio[0]) > $signed(best_prio_q);
    else head_wins = c_runs[0] < best_runs_q;
  end

  // tail for a pop-and-append during a scan is count-2 (after shift)
  always_comb begin
    ctrl = '0;
    ld_id = run_id_q;
    ld_prio = run_prio_q;
    ld_runs = yruns;
    tail_idx = count_q[IdxW-1:0];
    if (state_q == S_IDLE && req_acc) begin
      if (req_type_i == REQ_CREATE && count_q != CntW'(QueueDepth)) begin
        ctrl.load_tail = 1'b1;
        ld_id = next_id_q;
        ld_prio = thread_priority_i;
        ld_runs = '0;
      end else if (req_type_i == REQ_YIELD && run_v_q && count_q != CntW'(QueueDepth)) begin
        ctrl.load_tail = 1'b1;
      end
    end else if (state_q == S_SCAN) begin
      ctrl.shift = 1'b1;
      tail_idx = IdxW'(count_q - CntW'(2));
      if (head_wins) begin
        if (best_v_q) begin
          ctrl.load_tail = 1'b1;
          ld_id = best_id_q;
          ld_prio = best_prio_q;
          ld_runs = best_runs_q;
        end
      end else begin
        ctrl.load_tail = 1'b1;
        ld_id = c_id[0];
        ld_prio = c_prio[0];
        ld_runs = c_runs[0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      left_q <= '0;
      run_v_q <= 1'b0;
      run_id_q <= '0;
      run_prio_q <= '0;
      run_runs_q <= '0;
      next_id_q <= '0;
      policy_q <= POL_RR;
      best_v_q <= 1'b0;
      best_id_q <= '0;
      best_prio_q <= '0;
      best_runs_q <= '0;
      rsp_v_q <= 1'b0;
      rsp_st_q <= ST_OK;
      rsp_id_q <= '0;
    end else begin
      if (psel && penable && pwrite && paddr == REG_PICK_POLICY) begin
        policy_q <= pwdata[1:0];
      end
      if (rsp_v_q && rsp_ready_i) rsp_v_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (req_acc) begin
            case (req_type_i)
              REQ_CREATE: begin
                rsp_v_q <= 1'b1;
                if (count_q == CntW'(QueueDepth)) begin
                  rsp_st_q <= ST_FULL;
                  rsp_id_q <= '0;
                end else begin
                  rsp_st_q <= ST_OK;
                  rsp_id_q <= next_id_q;
                  next_id_q <= next_id_q + 8'd1;
                  count_q <= count_q + CntW'(1);
                end
              end
              REQ_DISPATCH: begin
                if (run_v_q) begin
                  rsp_v_q <= 1'b1;
                  rsp_st_q <= ST_BUSY;
                  rsp_id_q <= '0;
                end else if (count_q == '0) begin
                  rsp_v_q <= 1'b1;
                  rsp_st_q <= ST_EMPTY;
                  rsp_id_q <= '0;
                end else begin
                  state_q <= S_SCAN;
                  left_q <= count_q;
                  best_v_q <= 1'b0;
                end
              end
              REQ_YIELD: begin
                rsp_v_q <= 1'b1;
                if (!run_v_q) begin
                  rsp_st_q <= ST_IDLE;
                  rsp_id_q <= '0;
                end else if (count_q == CntW'(QueueDepth)) begin
                  rsp_st_q <= ST_FULL;
                  rsp_id_q <= '0;
                end else begin
                  rsp_st_q <= ST_OK;
                  rsp_id_q <= run_id_q;
                  count_q <= count_q + CntW'(1);
                  run_v_q <= 1'b0;
                  run_id_q <= '0;
                  run_prio_q <= '0;
                  run_runs_q <= '0;
                end
              end
              default: begin
                rsp_v_q <= 1'b1;
                if (!run_v_q) begin
                  rsp_st_q <= ST_IDLE;
                  rsp_id_q <= '0;
                end else begin
                  rsp_st_q <= ST_OK;
                  rsp_id_q <= run_id_q;
                  run_v_q <= 1'b0;
                  run_id_q <= '0;
                  run_prio_q <= '0;
                  run_runs_q <= '0;
                end
              end
            endcase
          end
        end
        S_SCAN: begin
          if (head_wins) begin
            best_v_q <= 1'b1;
            best_id_q <= c_id[0];
            best_prio_q <= c_prio[0];
            best_runs_q <= c_runs[0];
          end
          left_q <= left_q - CntW'(1);
          if (left_q == CntW'(1)) state_q <= S_DONE;
        end
        S_DONE: begin
          count_q <= count_q - CntW'(1);
          run_v_q <= 1'b1;
          run_id_q <= best_id_q;
          run_prio_q <= best_prio_q;
          run_runs_q <= best_runs_q;
          rsp_v_q <= 1'b1;
          rsp_st_q <= ST_OK;
          rsp_id_q <= best_id_q;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign rsp_valid_o = rsp_v_q;
  assign status_o = rsp_st_q;
  assign thread_id_o = rsp_id_q;

endmodule

### sv/rqtp_checker.sv
module rqtp_checker import rqtp_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       req_valid_i,
  input logic       req_ready_o,
  input logic       rsp_valid_o,
  input logic       rsp_ready_i,
  input logic [2:0] status_o,
  input logic [7:0] thread_id_o
);

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && !rsp_ready_i |=> rsp_valid_o && $stable(status_o) && $stable(thread_id_o))
    else $error("result changed while stalled");

  a_id_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && status_o != ST_OK |-> thread_id_o == 8'd0)
    else $error("nonzero id on failed request");

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> status_o <= ST_BUSY)
    else $error("bad status");

  a_no_accept_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> !req_ready_o)
    else $error("request taken while result pending");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_o |=> !req_ready_o)
    else $error("second request taken before result");

endmodule

bind ready_queue_thread_picker_unit rqtp_checker u_rqtp_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .req_valid_i(req_valid_i), .req_ready_o(req_ready_o),
  .rsp_valid_o(rsp_valid_o), .rsp_ready_i(rsp_ready_i), .status_o(status_o),
  .thread_id_o(thread_id_o)
);
